// ===== hdl/cluster_circle_fit_macros.svh =====
// assertion macros shared by the checker
`ifndef CLUSTER_CIRCLE_FIT_MACROS_SVH
`define CLUSTER_CIRCLE_FIT_MACROS_SVH

// condition holds at every edge out of reset
`define CCF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// trigger implies consequence on the next edge
`define CCF_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ccf_pkg.sv =====
package ccf_pkg;
   localparam int DEF_MAX_POINTS  = 256;
   localparam int DEF_COORD_BITS  = 16;
   // csr register byte addresses
   localparam logic [2:0] ADDR_LENGTH_LIMIT = 3'd0;
   localparam int CSR_ADDR_BITS = 3;
   localparam int LIMIT_RESET   = 1024;
endpackage

// ===== hdl/cluster_circle_fit.sv =====
// channel  direction  handshake        payload
// req      in         valid / stall    point_x, point_y, last_point
// rsp      out        valid / stall    mean, pair length, circle, count, overflow
// csr      in         apb write/read   length_limit at byte address 0
//
// req_stall stays low while loading points
// after a last point: a pairwise scan of the stored points (skipped for fewer than
// two points), paced by the single read port of the point memory, then two
// divisions of the coordinate sums by the point count for the mean, the root steps
// for the pair length and a load of the result register
// reset is synchronous; the point memory is not cleared, only its fill count
// rsp holds in its output register while stalled; req is stalled until the
// result is loaded into that register
module cluster_circle_fit #(
   parameter int MAX_POINTS = ccf_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = ccf_pkg::DEF_COORD_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_point_x,
   input  logic signed [COORD_BITS-1:0]         req_point_y,
   input  logic                                 req_last_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [COORD_BITS-1:0]         rsp_mean_x,
   output logic signed [COORD_BITS-1:0]         rsp_mean_y,
   output logic [COORD_BITS:0]                  rsp_pair_length,
   output logic                                 rsp_circle_accepted,
   output logic signed [COORD_BITS-1:0]         rsp_circle_x,
   output logic signed [COORD_BITS-1:0]         rsp_circle_y,
   output logic [COORD_BITS-1:0]                rsp_circle_radius,
   output logic [$clog2(MAX_POINTS+1)-1:0]      rsp_point_count,
   output logic                                 rsp_overflowed,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ccf_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import ccf_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int SW = C + CW;
   localparam int DW = 2 * C + 1;
   localparam int RW = 2 * C + 2;

   typedef enum logic [3:0] {
      S_LOAD, S_PIV, S_LATCH, S_SCAN, S_DRAIN, S_DIVX, S_DIVY, S_SQRT, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [C:0]          limit_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic                drop_ff, drop_in;
   logic signed [SW-1:0] sumx_ff, sumx_in, sumy_ff, sumy_in;
   logic [CW-1:0]       i_ff, i_in, j_ff, j_in;
   logic                rdv_ff, rdv_in;
   logic [AW-1:0]       rd_addr;
   logic [2*C-1:0]      mem [MAX_POINTS];
   logic [2*C-1:0]      mem_q_ff;
   logic [2*C-1:0]      piv_ff, piv_in;
   logic [C-1:0]        dx_ff, dy_ff;
   logic                va_ff, vb_ff;
   logic [2*C-1:0]      sqx_ff, sqy_ff;
   logic [DW-1:0]       best_ff, best_in;
   logic signed [C-1:0] mean_x_ff, mean_x_in, mean_y_ff, mean_y_in;
   logic signed [C-1:0] held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic [C-1:0]        held_r_ff, held_r_in;
   logic [C:0]          len_ff, len_in;
   logic                acc_ff, acc_in;
   logic                accept, wr_en;
   logic                div_start, div_done, sqrt_start, sqrt_done;
   logic [SW-1:0]       div_num, div_quo;
   logic [C:0]          root;
   logic signed [C:0]   dxs, dys;
   logic [SW-1:0]       qneg;

   // csr port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_LENGTH_LIMIT) ? 32'(limit_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= (C + 1)'(LIMIT_RESET);
      end else if (psel && penable && pwrite && paddr == ADDR_LENGTH_LIMIT) begin
         limit_ff <= pwdata[C:0];
      end
   end

   assign req_stall = state_ff != S_LOAD;
   assign accept    = req_valid && !req_stall;
   assign wr_en     = accept && count_ff < CW'(MAX_POINTS);

   // point memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= {req_point_x, req_point_y};
      end
      mem_q_ff <= mem[rd_addr];
   end

   // distance pipeline: abs differences, squares, running maximum
   always_comb begin
      dxs = {mem_q_ff[2*C-1], mem_q_ff[2*C-1:C]} - {piv_ff[2*C-1], piv_ff[2*C-1:C]};
      dys = {mem_q_ff[C-1], mem_q_ff[C-1:0]} - {piv_ff[C-1], piv_ff[C-1:0]};
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dxs[C] ? C'(-dxs) : dxs[C-1:0];
      dy_ff  <= dys[C] ? C'(-dys) : dys[C-1:0];
      sqx_ff <= dx_ff * dx_ff;
      sqy_ff <= dy_ff * dy_ff;
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= rdv_ff;
         vb_ff <= va_ff;
      end
   end

   ccf_div #(.SW(SW), .CW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   ccf_sqrt #(.W(RW)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (RW'(best_ff)),
      .done  (sqrt_done),
      .root  (root)
   );

   assign qneg = -div_quo;

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      drop_in    = drop_ff;
      sumx_in    = sumx_ff;
      sumy_in    = sumy_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      rdv_in     = 1'b0;
      rd_addr    = j_ff[AW-1:0];
      piv_in     = piv_ff;
      best_in    = best_ff;
      mean_x_in  = mean_x_ff;
      mean_y_in  = mean_y_ff;
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      held_r_in  = held_r_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      div_start  = 1'b0;
      div_num    = sumx_ff[SW-1] ? SW'(-sumx_ff) : SW'(sumx_ff);
      sqrt_start = 1'b0;
      if (vb_ff && DW'(sqx_ff) + DW'(sqy_ff) > best_ff) begin
         best_in = DW'(sqx_ff) + DW'(sqy_ff);
      end
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  sumx_in  = sumx_ff + SW'(req_point_x);
                  sumy_in  = sumy_ff + SW'(req_point_y);
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last_point) begin
                  i_in     = '0;
                  best_in  = '0;
                  state_in = (count_in < CW'(2)) ? S_DRAIN : S_PIV;
               end
            end
         end
         S_PIV: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = S_LATCH;
         end
         S_LATCH: begin
            piv_in   = mem_q_ff;
            rd_addr  = AW'(i_ff + 1'b1);
            rdv_in   = 1'b1;
            j_in     = i_ff + CW'(2);
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (j_ff < count_ff) begin
               rdv_in = 1'b1;
               j_in   = j_ff + 1'b1;
            end else if (i_ff + CW'(2) < count_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_PIV;
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rdv_ff && !va_ff && !vb_ff) begin
               div_start = 1'b1;
               state_in  = S_DIVX;
            end
         end
         S_DIVX: begin
            div_num = sumy_ff[SW-1] ? SW'(-sumy_ff) : SW'(sumy_ff);
            if (div_done) begin
               mean_x_in = sumx_ff[SW-1] ? C'(qneg) : C'(div_quo);
               div_start = 1'b1;
               state_in  = S_DIVY;
            end
         end
         S_DIVY: begin
            if (div_done) begin
               mean_y_in  = sumy_ff[SW-1] ? C'(qneg) : C'(div_quo);
               sqrt_start = 1'b1;
               state_in   = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               len_in = root;
               acc_in = root < limit_ff;
               if (root < limit_ff) begin
                  held_x_in = mean_x_ff;
                  held_y_in = mean_y_ff;
                  held_r_in = root[C:1];
               end
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid || !rsp_stall) begin
               count_in = '0;
               drop_in  = 1'b0;
               sumx_in  = '0;
               sumy_in  = '0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   // state and registered result
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      piv_ff    <= piv_in;
      best_ff   <= best_in;
      mean_x_ff <= mean_x_in;
      mean_y_ff <= mean_y_in;
      len_ff    <= len_in;
      acc_ff    <= acc_in;
      if (state_ff == S_OUT && (!rsp_valid || !rsp_stall)) begin
         rsp_mean_x          <= mean_x_ff;
         rsp_mean_y          <= mean_y_ff;
         rsp_pair_length     <= len_ff;
         rsp_circle_accepted <= acc_ff;
         rsp_circle_x        <= held_x_ff;
         rsp_circle_y        <= held_y_ff;
         rsp_circle_radius   <= held_r_ff;
         rsp_point_count     <= count_ff;
         rsp_overflowed      <= drop_ff;
      end
      if (reset) begin
         state_ff  <= S_LOAD;
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         sumx_ff   <= '0;
         sumy_ff   <= '0;
         rdv_ff    <= 1'b0;
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_r_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         sumx_ff   <= sumx_in;
         sumy_ff   <= sumy_in;
         rdv_ff    <= rdv_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_r_ff <= held_r_in;
         if (state_ff == S_OUT && (!rsp_valid || !rsp_stall)) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end
endmodule

// ===== hdl/ccf_div.sv =====
module ccf_div #(
   parameter int SW = 25,
   parameter int CW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [SW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [SW-1:0] quotient
);
   import ccf_pkg::*;

   localparam int NW = $clog2(SW + 1);

   logic [CW-1:0] rem_ff, rem_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW:0]   rem_sh;
   logic          fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SW-1]};
      fits    = rem_sh >= {1'b0, divisor};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? CW'(rem_sh - {1'b0, divisor}) : rem_sh[CW-1:0];
         quo_in = {quo_ff[SW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == NW'(SW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== hdl/ccf_sqrt.sv =====
module ccf_sqrt #(
   parameter int W = 34
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [W-1:0]    value,
   output logic            done,
   output logic [W/2-1:0]  root
);
   import ccf_pkg::*;

   logic [W-1:0] v_ff, v_in;
   logic [W-1:0] root_ff, root_in;
   logic [W-1:0] bit_ff, bit_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [W-1:0] trial;

   // two radicand bits per cycle
   always_comb begin
      trial   = root_ff + bit_ff;
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = value;
         root_in = '0;
         bit_in  = W'(1) << (W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in    = v_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_in == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff[W/2-1:0];
endmodule

// ===== hdl/ccf_checker.sv =====
`include "cluster_circle_fit_macros.svh"

module ccf_checker #(
   parameter int MAX_POINTS = ccf_pkg::DEF_MAX_POINTS,
   parameter int COORD_BITS = ccf_pkg::DEF_COORD_BITS
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic signed [COORD_BITS-1:0]       req_point_x,
   input logic signed [COORD_BITS-1:0]       req_point_y,
   input logic                               req_last_point,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic signed [COORD_BITS-1:0]       rsp_mean_x,
   input logic signed [COORD_BITS-1:0]       rsp_mean_y,
   input logic [COORD_BITS:0]                rsp_pair_length,
   input logic                               rsp_circle_accepted,
   input logic signed [COORD_BITS-1:0]       rsp_circle_x,
   input logic signed [COORD_BITS-1:0]       rsp_circle_y,
   input logic [COORD_BITS-1:0]              rsp_circle_radius,
   input logic [$clog2(MAX_POINTS+1)-1:0]    rsp_point_count,
   input logic                               rsp_overflowed,
   input logic                               psel,
   input logic                               penable,
   input logic                               pwrite,
   input logic [ccf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input logic [31:0]                        pwdata,
   input logic [31:0]                        prdata,
   input logic                               pready
);
   import ccf_pkg::*;

   // a last point starts the fit, so no further item is taken next cycle
   `CCF_ASSERT_NEXT(a_last_stalls, clock, reset,
      req_valid && !req_stall && req_last_point, req_stall,
      "item accepted right after a last point")

   // a stalled result holds its valid, pair length and mean x
   `CCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pair_length) && $stable(rsp_mean_x),
      "stalled result changed")

   // every result counts at least one point
   `CCF_ASSERT_ALWAYS(a_count_nonzero, clock, reset,
      !rsp_valid || rsp_point_count != '0, "result with no points")

   // an accepted circle is the mean with half the pair length
   `CCF_ASSERT_ALWAYS(a_circle_match, clock, reset,
      !(rsp_valid && rsp_circle_accepted) ||
      (rsp_circle_x == rsp_mean_x && rsp_circle_y == rsp_mean_y &&
       rsp_circle_radius == rsp_pair_length[COORD_BITS:1]),
      "accepted circle differs from mean and half length")
endmodule

bind cluster_circle_fit ccf_checker #(
   .MAX_POINTS (MAX_POINTS),
   .COORD_BITS (COORD_BITS)
) u_ccf_checker (.*);
